// ----- rtl/soc_kf_pkg.sv -----
// Package for the state-of-charge estimator: constants, register indexes,
// sequencer states, divider status struct and the OCV inverse curve table.
// No dependencies.
package soc_kf_pkg;

	localparam int CURVE_POINTS = 64;
	localparam int SEG_W = $clog2(CURVE_POINTS);
	localparam int P_W = 16 + SEG_W;

	localparam logic [22:0] SOC_FULL = 23'd6553600;
	localparam int DVD_W = 48;
	localparam int DVS_W = 33;
	localparam int CNT_W = $clog2(DVD_W + 1);

	localparam logic [2:0] REG_CAP  = 3'd0;
	localparam logic [2:0] REG_Q    = 3'd1;
	localparam logic [2:0] REG_R    = 3'd2;
	localparam logic [2:0] REG_ISOC = 3'd3;
	localparam logic [2:0] REG_ICOV = 3'd4;
	localparam logic [2:0] REG_LIM  = 3'd5;
	localparam logic [2:0] REG_CELL = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_QSTART,
		ST_DIVQ,
		ST_PRED,
		ST_VPREP,
		ST_VCMP,
		ST_DIVU,
		ST_INTERP,
		ST_LERP,
		ST_MEAS,
		ST_KSTART,
		ST_DIVK,
		ST_ADJ,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef logic [16:0] curve_t [CURVE_POINTS];

	function automatic logic [63:0] pow9_q16(input logic [63:0] z);
		logic [63:0] p;
		p = z;
		for (int k = 1; k < 9; k++) begin
			p = (p * z) >> 16;
		end
		return p;
	endfunction

	function automatic curve_t build_curve();
		curve_t tab;
		logic [63:0] x;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		logic [63:0] prod;
		for (int i = 0; i < CURVE_POINTS; i++) begin
			x = (64'(i) * 64'd65536) / 64'(CURVE_POINTS - 1);
			lo = 64'd0;
			hi = 64'd65536;
			while (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				if (pow9_q16(mid) <= x) begin
					lo = mid;
				end else begin
					hi = mid - 64'd1;
				end
			end
			prod = (x * lo) >> 16;
			tab[i] = prod[16:0];
		end
		return tab;
	endfunction

	localparam curve_t CURVE_TAB = build_curve();

endpackage

// ----- rtl/soc_kf_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
// Depends on soc_kf_pkg.
module soc_kf_div import soc_kf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output div_stat_t        stat
);

	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] quo_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   rem_sh;
	logic             ge;

	assign rem_sh = {rem_q, quo_q[DVD_W-1]};
	assign ge = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= DVS_W'(rem_sh - {1'b0, dvs_q});
			end else begin
				rem_q <= rem_sh[DVS_W-1:0];
			end
			quo_q <= {quo_q[DVD_W-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign stat = '{busy: busy_q, done: done_q};

endmodule

// ----- rtl/soc_kalman_estimator.sv -----
// Scalar Kalman state-of-charge estimator, top level: sequencer, datapath,
// configuration registers. Depends on soc_kf_pkg and soc_kf_div.
//
// Input channel (in_valid/in_stall) carries one sample per transaction:
// pack voltage, signed current, temperature and step time. Output channel
// (out_valid/out_stall) returns one result per sample: updated estimate,
// covariance and a flag telling whether the voltage correction was applied.
// in_stall is low only while the sequencer is idle; a result waiting in the
// output register does not block the next sample.
// Each sample runs through one shared 48-bit restoring divider, one bit per
// cycle: the coulomb-count division always; when the current is below the
// limit, the OCV division if the voltage lies inside the curve and the gain
// division if the predicted covariance plus R is nonzero. The result is
// registered as the sequencer leaves ST_FIN, which waits out any output stall.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready; writing initial_soc reloads the estimate and covariance.
// Reset loads the register defaults, fifty percent charge and the default
// covariance, and leaves the output channel empty.
// A stalled result holds in the output register until taken.
module soc_kalman_estimator import soc_kf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [17:0]        pack_voltage_mv,
	input  logic signed [18:0] current_ma,
	input  logic signed [11:0] temperature_dc,
	input  logic [15:0]        step_ms,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [22:0]        soc_estimate,
	output logic [31:0]        covariance,
	output logic               voltage_used,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);

	state_t state_q, state_d;

	logic [17:0] cap_q;
	logic [31:0] q_q;
	logic [31:0] r_q;
	logic [31:0] icov_q;
	logic [17:0] lim_q;
	logic [5:0]  cells_q;

	logic [22:0] soc_q;
	logic [31:0] cov_q;

	logic [17:0] v_q;
	logic [18:0] mag_q;
	logic        dis_q;
	logic [11:0] t_q;
	logic [15:0] dt_q;

	logic [34:0] prod_q;
	logic [28:0] capk_q;
	logic [22:0] pred_q;
	logic [31:0] pp_q;
	logic        used_q;
	logic [21:0] d_q;
	logic [33:0] num_q;
	logic [15:0] u_q;
	logic [16:0] a_q;
	logic [16:0] diff_q;
	logic        dneg_q;
	logic [15:0] frac_q;
	logic [16:0] y_q;
	logic [22:0] meas_q;
	logic [16:0] k_q;
	logic        dsgn_q;
	logic [39:0] adjm_q;
	logic [48:0] covm_q;

	logic        out_valid_q;
	logic [22:0] out_soc_q;
	logic [31:0] out_cov_q;
	logic        out_used_q;

	logic             div_start;
	logic [DVD_W-1:0] div_dvd;
	logic [DVS_W-1:0] div_dvs;
	logic [DVD_W-1:0] div_quo;
	div_stat_t        div_st;

	logic        in_acc;
	logic        cfg_acc;
	logic        out_free;
	logic [17:0] cap_eff;
	logic [5:0]  cells_eff;
	logic [18:0] mag_w;
	logic [16:0] tk;
	logic [33:0] t3;
	logic [33:0] t42;
	logic [31:0] diffv;
	logic [32:0] sum_w;
	logic [48:0] pred_add;
	logic [32:0] pp_w;
	logic [P_W-1:0]   p_w;
	logic [SEG_W-1:0] seg;
	logic [15:0] frac;
	logic [16:0] ta;
	logic [16:0] tb;
	logic [32:0] lerp_m;
	logic [22:0] ad;
	logic [16:0] km;
	logic [23:0] adj;
	logic [23:0] soc_add;
	logic [22:0] soc_new;
	logic [31:0] cov_new;

	soc_kf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.stat     (div_st)
	);

	assign in_acc = in_valid && !in_stall;
	assign cfg_acc = cfg_valid && cfg_ready;
	assign out_free = !(out_valid_q && out_stall);
	assign cap_eff = (cap_q == 18'd0) ? 18'd1 : cap_q;
	assign cells_eff = (cells_q == 6'd0) ? 6'd1 : cells_q;
	assign mag_w = current_ma[18] ? 19'(-current_ma) : current_ma;

	assign tk = 17'(17'd46000 + {{5{t_q[11]}}, t_q});
	assign t3 = 34'(34'(d_q) * 34'd3000);
	assign t42 = 34'(34'(d_q) * 34'd4200);
	assign diffv = 32'(num_q - t3);
	assign sum_w = 33'(pp_q) + 33'(r_q);
	assign pred_add = 49'(div_quo) + 49'(soc_q);
	assign pp_w = 33'(cov_q) + 33'(q_q);

	always_comb begin
		p_w = P_W'(P_W'(u_q) * P_W'(CURVE_POINTS - 1));
		seg = p_w[P_W-1:16];
		frac = p_w[15:0];
		if (seg >= SEG_W'(CURVE_POINTS - 1)) begin
			seg = SEG_W'(CURVE_POINTS - 2);
			frac = 16'hFFFF;
		end
		ta = CURVE_TAB[seg];
		tb = CURVE_TAB[seg + SEG_W'(1)];
	end

	assign lerp_m = 33'(diff_q) * 33'(frac_q);
	assign ad = (meas_q < pred_q) ? (pred_q - meas_q) : (meas_q - pred_q);
	assign km = 17'd65536 - k_q;
	assign adj = 24'((adjm_q + 40'd32768) >> 16);
	assign soc_add = 24'(pred_q) + adj;

	always_comb begin
		if (!used_q) begin
			soc_new = pred_q;
			cov_new = pp_q;
		end else begin
			if (dsgn_q) begin
				soc_new = (adj >= 24'(pred_q)) ? 23'd0 : 23'(24'(pred_q) - adj);
			end else begin
				soc_new = (soc_add > 24'(SOC_FULL)) ? SOC_FULL : soc_add[22:0];
			end
			cov_new = covm_q[47:16];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_MUL;
			ST_MUL:    state_d = ST_QSTART;
			ST_QSTART: state_d = ST_DIVQ;
			ST_DIVQ:   if (div_st.done) state_d = ST_PRED;
			ST_PRED:   state_d = (mag_q < 19'(lim_q)) ? ST_VPREP : ST_FIN;
			ST_VPREP:  state_d = ST_VCMP;
			ST_VCMP: begin
				if (num_q <= t3 || num_q >= t42) begin
					state_d = ST_KSTART;
				end else begin
					state_d = ST_DIVU;
				end
			end
			ST_DIVU:   if (div_st.done) state_d = ST_INTERP;
			ST_INTERP: state_d = ST_LERP;
			ST_LERP:   state_d = ST_MEAS;
			ST_MEAS:   state_d = ST_KSTART;
			ST_KSTART: state_d = (sum_w == 33'd0) ? ST_ADJ : ST_DIVK;
			ST_DIVK:   if (div_st.done) state_d = ST_ADJ;
			ST_ADJ:    state_d = ST_FIN;
			ST_FIN:    if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		cfg_ready = 1'b1;
		div_start = 1'b0;
		div_dvd = 48'({prod_q, 12'b0}) + 48'(capk_q);
		div_dvs = 33'({capk_q, 1'b0});
		case (state_q)
			ST_QSTART: div_start = 1'b1;
			ST_VCMP: begin
				div_start = !(num_q <= t3 || num_q >= t42);
				div_dvd = 48'({diffv, 16'b0});
				div_dvs = 33'(33'(d_q) * 33'd1200);
			end
			ST_KSTART: begin
				div_start = (sum_w != 33'd0);
				div_dvd = 48'({pp_q, 16'b0});
				div_dvs = sum_w;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cap_q <= 18'd100000;
			q_q <= 32'd655;
			r_q <= 32'd65536;
			icov_q <= 32'd65536;
			lim_q <= 18'd2000;
			cells_q <= 6'd4;
			soc_q <= 23'd3276800;
			cov_q <= 32'd65536;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				case (cfg_index)
					REG_CAP:  cap_q <= cfg_data[17:0];
					REG_Q:    q_q <= cfg_data;
					REG_R:    r_q <= cfg_data;
					REG_ISOC: begin
						soc_q <= (cfg_data[22:0] > SOC_FULL) ? SOC_FULL : cfg_data[22:0];
						cov_q <= icov_q;
					end
					REG_ICOV: icov_q <= cfg_data;
					REG_LIM:  lim_q <= cfg_data[17:0];
					REG_CELL: cells_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_FIN && out_free) begin
				soc_q <= soc_new;
				cov_q <= cov_new;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			v_q <= pack_voltage_mv;
			mag_q <= mag_w;
			dis_q <= !current_ma[18] && (current_ma != 19'sd0);
			t_q <= temperature_dc;
			dt_q <= step_ms;
		end
		case (state_q)
			ST_MUL: begin
				prod_q <= 35'(mag_q) * 35'(dt_q);
				capk_q <= 29'(29'(cap_eff) * 29'd1125);
			end
			ST_PRED: begin
				if (dis_q) begin
					pred_q <= (div_quo >= 48'(soc_q)) ? 23'd0 : 23'(soc_q - 23'(div_quo));
				end else begin
					pred_q <= (pred_add > 49'(SOC_FULL)) ? SOC_FULL : pred_add[22:0];
				end
				pp_q <= pp_w[32] ? 32'hFFFF_FFFF : pp_w[31:0];
				used_q <= (mag_q < 19'(lim_q));
			end
			ST_VPREP: begin
				d_q <= 22'(22'(cells_eff) * 22'(tk));
				num_q <= 34'(34'(v_q) * 34'd46250);
			end
			ST_VCMP: begin
				meas_q <= (num_q <= t3) ? 23'd0 : SOC_FULL;
			end
			ST_DIVU: u_q <= div_quo[15:0];
			ST_INTERP: begin
				a_q <= ta;
				dneg_q <= (tb < ta);
				diff_q <= (tb >= ta) ? (tb - ta) : (ta - tb);
				frac_q <= frac;
			end
			ST_LERP: begin
				y_q <= dneg_q ? (a_q - lerp_m[32:16]) : (a_q + lerp_m[32:16]);
			end
			ST_MEAS: meas_q <= 23'(24'(y_q) * 24'd100);
			ST_KSTART: k_q <= 17'd0;
			ST_DIVK: k_q <= div_quo[16:0];
			ST_ADJ: begin
				dsgn_q <= (meas_q < pred_q);
				adjm_q <= 40'(k_q) * 40'(ad);
				covm_q <= 49'(km) * 49'(pp_q);
			end
			ST_FIN: begin
				if (out_free) begin
					out_soc_q <= soc_new;
					out_cov_q <= cov_new;
					out_used_q <= used_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign soc_estimate = out_soc_q;
	assign covariance = out_cov_q;
	assign voltage_used = out_used_q;

	a_soc_range: assert property (@(posedge clk) disable iff (!arst_n)
		soc_q <= SOC_FULL) else $error("estimate above full charge");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> (state_q == ST_DIVQ || state_q == ST_DIVU || state_q == ST_DIVK))
		else $error("divider finished outside a wait state");

	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result issued without finishing a sample");

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy) else $error("divider restarted while busy");

endmodule

// ----- test/soc_kalman_estimator_tb.sv -----
// Self-checking testbench for soc_kalman_estimator: directed and random samples
// checked against an in-bench fixed-point Kalman predictor, with random idling.
// Depends on soc_kf_pkg and the estimator RTL.
`timescale 1ns / 1ps

module soc_kalman_estimator_tb;
	import soc_kf_pkg::*;

	localparam int NODES = CURVE_POINTS;
	localparam longint FULL = 6553600;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic [22:0] soc;
		logic [31:0] cov;
		logic        used;
	} soc_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [17:0]        pack_voltage_mv = '0;
	logic signed [18:0] current_ma = '0;
	logic signed [11:0] temperature_dc = '0;
	logic [15:0]        step_ms = '0;
	logic               out_valid;
	logic               out_stall = 1'b1;
	logic [22:0]        soc_estimate;
	logic [31:0]        covariance;
	logic               voltage_used;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [2:0]         cfg_index = '0;
	logic [31:0]        cfg_data = '0;

	// predictor copy of configuration and state
	longint unsigned cap_mah = 100000, q_noise = 655, r_noise = 65536;
	longint unsigned isoc_reg = 3276800, icov_reg = 65536, lim_ma = 2000, cells_reg = 4;
	longint          soc_st = 3276800;
	longint unsigned cov_st = 65536;
	longint unsigned ocv_curve [NODES];

	soc_result_t expected_results [$];
	int  errors = 0;
	int  idle_cycles = 0;
	bit  rx_no_idle = 0;
	bit  rx_hold_long = 0;
	bit  tx_no_idle = 0;

	soc_kalman_estimator u_top (.*);

	always #5 clk = ~clk;

	function automatic longint unsigned q16_pow9(longint unsigned z);
		longint unsigned acc = z;
		for (int n = 0; n < 8; n++) acc = (acc * z) >> 16;
		return acc;
	endfunction

	function automatic void build_ocv_curve();
		longint unsigned x, z, trial;
		for (int i = 0; i < NODES; i++) begin
			x = (longint'(i) * 65536) / (NODES - 1);
			z = 0;
			for (int b = 16; b >= 0; b--) begin
				trial = z | (64'd1 << b);
				if (trial <= 65536 && q16_pow9(trial) <= x) z = trial;
			end
			ocv_curve[i] = (x * z) >> 16;
		end
	endfunction

	function automatic longint ocv_soc(longint unsigned v_mv, longint t_dc);
		longint unsigned nc, dd, num, u, p, seg, frac, a, b, y;
		nc = cells_reg ? cells_reg : 1;
		dd = nc * longint'(46000 + t_dc);
		num = v_mv * 46250;
		if (num <= 3000 * dd) return 0;
		if (num >= 4200 * dd) return FULL;
		u = ((num - 3000 * dd) * 65536) / (1200 * dd);
		p = u * (NODES - 1);
		seg = p >> 16;
		frac = p & 16'hFFFF;
		if (seg >= NODES - 1) begin
			seg = NODES - 2;
			frac = 16'hFFFF;
		end
		a = ocv_curve[seg];
		b = ocv_curve[seg + 1];
		y = (b >= a) ? a + (((b - a) * frac) >> 16) : a - (((a - b) * frac) >> 16);
		return longint'(y * 100);
	endfunction

	function automatic soc_result_t kalman_step(logic [17:0] v, logic signed [18:0] cur,
			logic signed [11:0] t, logic [15:0] dt);
		soc_result_t r;
		longint c, pred, meas, diff, adj;
		longint unsigned mag, capv, den, delta, pp, sum, k, ad;
		c = cur;
		mag = c < 0 ? -c : c;
		capv = cap_mah ? cap_mah : 1;
		den = 3600000 * capv;
		delta = (mag * dt * 6553600 + den / 2) / den;
		pred = (c > 0) ? soc_st - longint'(delta) : soc_st + longint'(delta);
		if (pred < 0) pred = 0;
		if (pred > FULL) pred = FULL;
		pp = cov_st + q_noise;
		if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
		r.used = mag < lim_ma;
		if (r.used) begin
			meas = ocv_soc(v, t);
			sum = pp + r_noise;
			k = sum ? (pp * 65536) / sum : 0;
			diff = meas - pred;
			ad = diff < 0 ? -diff : diff;
			adj = longint'((k * ad + 32768) >> 16);
			soc_st = diff < 0 ? pred - adj : pred + adj;
			cov_st = ((65536 - k) * pp) >> 16;
		end else begin
			soc_st = pred;
			cov_st = pp;
		end
		if (soc_st < 0) soc_st = 0;
		if (soc_st > FULL) soc_st = FULL;
		r.soc = soc_st[22:0];
		r.cov = cov_st[31:0];
		return r;
	endfunction

	function automatic void apply_register(logic [2:0] idx, logic [31:0] d);
		case (idx)
			REG_CAP:  cap_mah = d[17:0];
			REG_Q:    q_noise = d;
			REG_R:    r_noise = d;
			REG_ISOC: begin
				isoc_reg = d[22:0];
				soc_st = (longint'(isoc_reg) > FULL) ? FULL : longint'(isoc_reg);
				cov_st = icov_reg;
			end
			REG_ICOV: icov_reg = d;
			REG_LIM:  lim_ma = d[17:0];
			REG_CELL: cells_reg = d[5:0];
			default: ;
		endcase
	endfunction

	task automatic send_sample(logic [17:0] v, logic signed [18:0] cur,
			logic signed [11:0] t, logic [15:0] dt);
		int gap;
		gap = tx_no_idle ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pack_voltage_mv <= v;
		current_ma <= cur;
		temperature_dc <= t;
		step_ms <= dt;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(kalman_step(v, cur, t, dt));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_register(logic [2:0] idx, logic [31:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		apply_register(idx, d);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// realistic sample: cell voltage near the curve, current often below the limit
	task automatic send_random_sample();
		longint unsigned nc;
		logic [17:0] v;
		logic signed [18:0] cur;
		logic signed [11:0] t;
		logic [15:0] dt;
		nc = cells_reg ? cells_reg : 1;
		if ($urandom_range(0, 4) == 0) begin
			v = $urandom;
			cur = $urandom;
			t = $urandom;
			dt = $urandom;
		end else begin
			v = nc * $urandom_range(2900, 4300);
			if ($urandom_range(0, 1)) cur = $signed(19'($urandom_range(0, 4000))) - 19'sd2000;
			else cur = $signed(19'($urandom_range(0, 200000))) - 19'sd100000;
			t = $signed(12'($urandom_range(0, 1650))) - 12'sd400;
			dt = $urandom_range(0, 5000);
		end
		send_sample(v, cur, t, dt);
	endtask

	always @(posedge clk) begin
		soc_result_t e;
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result soc=%0d cov=%0d used=%0d", $time,
					soc_estimate, covariance, voltage_used);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (soc_estimate !== e.soc) begin
					$display("%0t: soc_estimate expected %0d actual %0d", $time, e.soc,
						soc_estimate);
					errors++;
				end
				if (covariance !== e.cov) begin
					$display("%0t: covariance expected %0d actual %0d", $time, e.cov,
						covariance);
					errors++;
				end
				if (voltage_used !== e.used) begin
					$display("%0t: voltage_used expected %0d actual %0d", $time, e.used,
						voltage_used);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			n = rx_no_idle ? 0 : $urandom_range(0, 5);
			if (rx_hold_long) begin
				n = 300;
				rx_hold_long = 0;
			end
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic test_defaults();
		repeat (6) send_random_sample();
		drain();
	endtask

	task automatic test_field_extremes();
		send_sample(18'd0, 19'sd0, 12'sd250, 16'd0);
		send_sample(18'h3FFFF, 19'sd0, 12'sd250, 16'd1000);
		send_sample(18'd12000, 19'sd1999, -12'sd400, 16'd1000);
		send_sample(18'd16800, -19'sd1999, 12'sd1250, 16'd1000);
		send_sample(18'd14800, 19'sd2000, 12'sd250, 16'd1000);
		send_sample(18'd14800, -19'sd2000, 12'sd250, 16'd1000);
		send_sample(18'd14800, 19'sh3FFFF, 12'sh7FF, 16'hFFFF);
		send_sample(18'd14800, 19'sh3FFFF, -12'sd2048, 16'hFFFF);
		send_sample(18'd14800, -19'sd262144, 12'sd0, 16'hFFFF);
		send_sample(18'd14800, -19'sd262144, 12'sd0, 16'hFFFF);
		send_sample(18'd15000, 19'sd0, 12'sd0, 16'd0);
		send_sample(18'h2AAAA, 19'sh15555, 12'sh555, 16'hAAAA);
		send_sample(18'h15555, -19'sh15556, -12'sh556, 16'h5555);
		drain();
	endtask

	task automatic test_register_extremes();
		write_register(REG_CAP, 32'd0);
		send_sample(18'd14800, 19'sd100000, 12'sd250, 16'd100);
		drain();
		write_register(REG_CAP, 32'h3FFFF);
		write_register(REG_CELL, 32'd0);
		send_sample(18'd3700, 19'sd10, 12'sd250, 16'd100);
		drain();
		write_register(REG_CELL, 32'd32);
		send_sample(18'd118400, 19'sd10, 12'sd250, 16'd100);
		drain();
		write_register(REG_CELL, 32'd63);
		write_register(REG_LIM, 32'd0);
		send_sample(18'd230000, 19'sd0, 12'sd250, 16'd100);
		drain();
		write_register(REG_LIM, 32'h3FFFF);
		write_register(REG_Q, 32'd0);
		write_register(REG_R, 32'd0);
		write_register(REG_ICOV, 32'd0);
		write_register(REG_ISOC, 32'h7FFFFF);
		send_sample(18'd230000, 19'sd5, 12'sd250, 16'd100);
		drain();
		write_register(REG_Q, 32'hFFFF_FFFF);
		write_register(REG_R, 32'hFFFF_FFFF);
		write_register(REG_ICOV, 32'hFFFF_FFFF);
		write_register(REG_ISOC, 32'd0);
		write_register(3'd7, 32'h1234_5678);
		send_sample(18'd230000, -19'sd5, 12'sd250, 16'd100);
		send_sample(18'd230000, -19'sd262143, 12'sd250, 16'hFFFF);
		drain();
	endtask

	task automatic test_random_phases();
		for (int phase = 0; phase < 6; phase++) begin
			write_register(REG_CAP, $urandom_range(0, 1) ? $urandom_range(1, 262143)
				: $urandom_range(100, 5000));
			write_register(REG_Q, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 70000));
			write_register(REG_R, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 300000));
			write_register(REG_ICOV, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 200000));
			write_register(REG_ISOC, $urandom_range(0, 8388607));
			write_register(REG_LIM, $urandom_range(0, 3) == 0 ? $urandom_range(0, 262143)
				: $urandom_range(500, 3000));
			write_register(REG_CELL, $urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
				: $urandom_range(1, 32));
			tx_no_idle = (phase == 2);
			rx_no_idle = (phase == 2);
			repeat (150) send_random_sample();
			drain();
		end
		tx_no_idle = 0;
		rx_no_idle = 0;
	endtask

	task automatic test_output_backpressure();
		rx_hold_long = 1;
		repeat (8) send_random_sample();
		drain();
	endtask

	initial begin
		build_ocv_curve();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_field_extremes();
		test_register_extremes();
		test_output_backpressure();
		test_random_phases();
		drain();
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/soc_kf_pkg.sv
rtl/soc_kf_div.sv
rtl/soc_kalman_estimator.sv
test/soc_kalman_estimator_tb.sv
